### src/mwm_pkg.sv
// Shared types and constants for the mecanum wheel mixer.
package mwm_pkg;

  // Widths of the command words and the wheel-sum intermediates.
  localparam int CMD_W      = 16;
  localparam int SUM_W      = 18;
  localparam int MAG_W      = 17;
  localparam int NUM_WHEELS = 4;

  // Wheel lane indices.
  localparam int LANE_FL = 0;
  localparam int LANE_FR = 1;
  localparam int LANE_RL = 2;
  localparam int LANE_RR = 3;

  // Saturation limits of the motor command range.
  localparam int CMD_MAX = 32767;
  localparam int CMD_MIN = -32768;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [MAG_W-1:0]        mag_t;

  // Input word: one drive command.
  typedef struct packed {
    logic signed [CMD_W-1:0] strafe_cmd;
    logic signed [CMD_W-1:0] axis_cmd;
    logic signed [CMD_W-1:0] rotate_cmd;
  } cmd_word_t;

  // Output word: four motor commands.
  typedef struct packed {
    logic signed [CMD_W-1:0] front_left_out;
    logic signed [CMD_W-1:0] front_right_out;
    logic signed [CMD_W-1:0] rear_left_out;
    logic signed [CMD_W-1:0] rear_right_out;
  } mix_word_t;

  // Data handed from cell to cell along the divider chain.
  typedef struct packed {
    sum_t [NUM_WHEELS-1:0] wheel;
    mag_t [NUM_WHEELS-1:0] rem;
    mag_t                  divisor;
    logic                  scale;
  } lane_set_t;

endpackage

### src/mecanum_wheel_mixer_core.sv
// An accepted input word passes the sum stage, the maximum stage, the FRAC_BITS + 1 division
// cells and the output register. Throughput: one word per cycle while out_stall is low; each cell
// yields one quotient bit for all four wheels, so the cell chain sets the latency, not the rate.
// Every stage has its own valid bit and moves on when the stage after it is free.
// Reset (synchronous, active low) clears only the valid bits; payload registers are not reset.
module mecanum_wheel_mixer_core #(
  parameter int FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mwm_pkg::cmd_word_t in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output mwm_pkg::mix_word_t out_word
);

  localparam int QW = FRAC_BITS + 1;
  localparam int NS = QW + 2;

  logic [NS-1:0]                                 vld;
  logic [NS:0]                                   rdy;
  mwm_pkg::lane_set_t                            cd [QW+1];
  logic [mwm_pkg::NUM_WHEELS-1:0][QW-1:0]        qd [QW+1];

  // A stage may advance when it is empty or the next stage advances.
  assign rdy[NS] = !out_valid || !out_stall;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign in_stall = !rdy[0];

  // Wheel sums and largest magnitude.
  mwm_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv_sum (rdy[0]),
    .adv_max (rdy[1]),
    .v_in    (in_valid),
    .d_in    (in_word),
    .v_sum   (vld[0]),
    .v_max   (vld[1]),
    .d_out   (cd[0])
  );

  assign qd[0] = '0;

  // Chain of division cells, most significant quotient bit first.
  for (genvar c = 0; c < QW; c++) begin : g_cell
    mwm_div_cell #(
      .QW    (QW),
      .FIRST (c == 0)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (rdy[c+2]),
      .v_in  (vld[c+1]),
      .d_in  (cd[c]),
      .q_in  (qd[c]),
      .v_out (vld[c+2]),
      .d_out (cd[c+1]),
      .q_out (qd[c+1])
    );
  end

  // Sign, orientation and saturation into the output register.
  mwm_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (rdy[NS]),
    .v_in      (vld[NS-1]),
    .d_in      (cd[QW]),
    .q_in      (qd[QW]),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // An accepted word always lands in the sum stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted input word did not enter the sum stage");

  // The input side only stalls when a result is waiting and held off.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // With the output side free, the pipeline always takes a new word.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output side was free");

endmodule

### src/mwm_front.sv
// Front stages: wheel sums, then magnitudes, largest magnitude and scale decision.
module mwm_front #(
  parameter int FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv_sum,
  input  logic               adv_max,
  input  logic               v_in,
  input  mwm_pkg::cmd_word_t d_in,
  output logic               v_sum,
  output logic               v_max,
  output mwm_pkg::lane_set_t d_out
);

  localparam int CW = ((FRAC_BITS + 1 > mwm_pkg::MAG_W) ? FRAC_BITS + 1 : mwm_pkg::MAG_W) + 1;

  logic                                       v_sum_r;
  logic                                       v_max_r;
  mwm_pkg::sum_t [mwm_pkg::NUM_WHEELS-1:0]    wheel_r;
  mwm_pkg::sum_t [mwm_pkg::NUM_WHEELS-1:0]    wheel_nxt;
  mwm_pkg::mag_t [mwm_pkg::NUM_WHEELS-1:0]    mag;
  mwm_pkg::mag_t                              max_01;
  mwm_pkg::mag_t                              max_23;
  mwm_pkg::mag_t                              max_all;
  mwm_pkg::lane_set_t                         set_r;
  mwm_pkg::lane_set_t                         set_nxt;
  mwm_pkg::sum_t                              str_x;
  mwm_pkg::sum_t                              fwd_x;
  mwm_pkg::sum_t                              rot_x;

  // Forward speed is the negated axis; the sums are exact at this width.
  always_comb begin
    str_x = mwm_pkg::SUM_W'(d_in.strafe_cmd);
    rot_x = mwm_pkg::SUM_W'(d_in.rotate_cmd);
    fwd_x = -mwm_pkg::sum_t'(mwm_pkg::SUM_W'(d_in.axis_cmd));
    wheel_nxt[mwm_pkg::LANE_FL] = fwd_x + rot_x + str_x;
    wheel_nxt[mwm_pkg::LANE_FR] = fwd_x - rot_x - str_x;
    wheel_nxt[mwm_pkg::LANE_RL] = fwd_x + rot_x - str_x;
    wheel_nxt[mwm_pkg::LANE_RR] = fwd_x - rot_x + str_x;
  end

  // Sum stage valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_sum_r <= 1'b0;
    end else if (adv_sum) begin
      v_sum_r <= v_in;
    end
  end

  // Sum stage payload.
  always_ff @(posedge clk) begin
    if (adv_sum && v_in) begin
      wheel_r <= wheel_nxt;
    end
  end

  // Magnitudes and a two-level maximum tree.
  always_comb begin
    for (int i = 0; i < mwm_pkg::NUM_WHEELS; i++) begin
      mag[i] = wheel_r[i][mwm_pkg::SUM_W-1] ? mwm_pkg::MAG_W'(-$signed(wheel_r[i]))
                                            : mwm_pkg::MAG_W'(wheel_r[i]);
    end
    max_01  = (mag[0] > mag[1]) ? mag[0] : mag[1];
    max_23  = (mag[2] > mag[3]) ? mag[2] : mag[3];
    max_all = (max_01 > max_23) ? max_01 : max_23;
    set_nxt.wheel   = wheel_r;
    set_nxt.rem     = mag;
    set_nxt.divisor = max_all;
    set_nxt.scale   = {{(CW - mwm_pkg::MAG_W){1'b0}}, max_all} > (CW'(1) << FRAC_BITS);
  end

  // Maximum stage valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_max_r <= 1'b0;
    end else if (adv_max) begin
      v_max_r <= v_sum_r;
    end
  end

  // Maximum stage payload.
  always_ff @(posedge clk) begin
    if (adv_max && v_sum_r) begin
      set_r <= set_nxt;
    end
  end

  assign v_sum = v_sum_r;
  assign v_max = v_max_r;
  assign d_out = set_r;

endmodule

### src/mwm_div_cell.sv
// One restoring-division cell: yields one quotient bit for each of the four wheels.
module mwm_div_cell #(
  parameter int QW    = 16,
  parameter bit FIRST = 1'b0
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     adv,
  input  logic                                     v_in,
  input  mwm_pkg::lane_set_t                       d_in,
  input  logic [mwm_pkg::NUM_WHEELS-1:0][QW-1:0]   q_in,
  output logic                                     v_out,
  output mwm_pkg::lane_set_t                       d_out,
  output logic [mwm_pkg::NUM_WHEELS-1:0][QW-1:0]   q_out
);

  logic                                     v_r;
  mwm_pkg::lane_set_t                       d_r;
  mwm_pkg::lane_set_t                       d_nxt;
  logic [mwm_pkg::NUM_WHEELS-1:0][QW-1:0]   q_r;
  logic [mwm_pkg::NUM_WHEELS-1:0][QW-1:0]   q_nxt;
  logic [mwm_pkg::NUM_WHEELS-1:0][mwm_pkg::MAG_W:0] trial;
  logic [mwm_pkg::NUM_WHEELS-1:0]           ge;

  // The first cell tests the unshifted remainder, later cells shift it by one.
  always_comb begin
    d_nxt = d_in;
    for (int i = 0; i < mwm_pkg::NUM_WHEELS; i++) begin
      trial[i] = FIRST ? {1'b0, d_in.rem[i]} : {d_in.rem[i], 1'b0};
      ge[i]    = trial[i] >= {1'b0, d_in.divisor};
      d_nxt.rem[i] = ge[i] ? mwm_pkg::MAG_W'(trial[i] - {1'b0, d_in.divisor})
                           : mwm_pkg::MAG_W'(trial[i]);
      q_nxt[i] = {q_in[i][QW-2:0], ge[i]};
    end
  end

  // Valid bit of this cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  // Payload of this cell.
  always_ff @(posedge clk) begin
    if (adv && v_in) begin
      d_r <= d_nxt;
      q_r <= q_nxt;
    end
  end

  assign v_out = v_r;
  assign d_out = d_r;
  assign q_out = q_r;

endmodule

### src/mwm_back.sv
// Output stage: applies signs and motor orientation, saturates, holds the result word.
module mwm_back #(
  parameter int FRAC_BITS = 15
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                adv,
  input  logic                                                v_in,
  input  mwm_pkg::lane_set_t                                  d_in,
  input  logic [mwm_pkg::NUM_WHEELS-1:0][FRAC_BITS:0]         q_in,
  output logic                                                out_valid,
  output mwm_pkg::mix_word_t                                  out_word
);

  localparam int QW = FRAC_BITS + 1;
  localparam int XW = ((FRAC_BITS + 2 > mwm_pkg::SUM_W) ? FRAC_BITS + 2 : mwm_pkg::SUM_W) + 1;

  logic                                                       out_valid_r;
  mwm_pkg::mix_word_t                                         out_word_r;
  mwm_pkg::mix_word_t                                         word_nxt;
  logic signed [mwm_pkg::NUM_WHEELS-1:0][mwm_pkg::CMD_W-1:0]  res;
  logic [XW-1:0]                                              wx;
  logic [XW-1:0]                                              qx;
  logic [XW-1:0]                                              sel;
  logic signed [XW-1:0]                                       val;
  logic                                                       neg_lane;
  logic                                                       flip;

  // Saturate a wide signed value to the command range.
  function automatic logic [mwm_pkg::CMD_W-1:0] sat_cmd(input logic signed [XW-1:0] v);
    logic [mwm_pkg::CMD_W-1:0] r;
    if (v > $signed(XW'(mwm_pkg::CMD_MAX))) begin
      r = mwm_pkg::CMD_W'(mwm_pkg::CMD_MAX);
    end else if (v < $signed(XW'(mwm_pkg::CMD_MIN))) begin
      r = mwm_pkg::CMD_W'(mwm_pkg::CMD_MIN);
    end else begin
      r = v[mwm_pkg::CMD_W-1:0];
    end
    return r;
  endfunction

  // Pick quotient or raw sum; flip right-side lanes, and for the quotient also fold in the wheel sign.
  always_comb begin
    res = '0;
    wx = '0;
    qx = '0;
    sel = '0;
    val = '0;
    neg_lane = 1'b0;
    flip = 1'b0;
    for (int i = 0; i < mwm_pkg::NUM_WHEELS; i++) begin
      neg_lane = (i == mwm_pkg::LANE_FR) || (i == mwm_pkg::LANE_RR);
      wx   = {{(XW - mwm_pkg::SUM_W){d_in.wheel[i][mwm_pkg::SUM_W-1]}}, d_in.wheel[i]};
      qx   = {{(XW - QW){1'b0}}, q_in[i]};
      sel  = d_in.scale ? qx : wx;
      flip = d_in.scale ? (neg_lane ^ d_in.wheel[i][mwm_pkg::SUM_W-1]) : neg_lane;
      val  = flip ? -$signed(sel) : $signed(sel);
      res[i] = sat_cmd(val);
    end
    word_nxt.front_left_out  = res[mwm_pkg::LANE_FL];
    word_nxt.front_right_out = res[mwm_pkg::LANE_FR];
    word_nxt.rear_left_out   = res[mwm_pkg::LANE_RL];
    word_nxt.rear_right_out  = res[mwm_pkg::LANE_RR];
  end

  // Output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_in;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (adv && v_in) begin
      out_word_r <= word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### dv/tb_mecanum_wheel_mixer_core.sv
// Self-checking testbench for the mecanum wheel mixer core.
module tb_mecanum_wheel_mixer_core;

  localparam int FRAC_BITS      = 15;
  localparam int LATENCY        = FRAC_BITS + 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_LEN   = 300;

  typedef logic signed [mwm_pkg::CMD_W-1:0] cmd_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  mwm_pkg::cmd_word_t in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  mwm_pkg::mix_word_t out_word;

  // Words still owed by the block, oldest first.
  mwm_pkg::mix_word_t pending_mix_q[$];
  int                 mismatch_count = 0;
  int                 words_checked = 0;
  int                 quiet_cycles = 0;

  // Controls set by the test tasks; the receiver process reads rx_stalls_on and hold_off_req.
  bit tx_gaps_on = 1'b0;
  bit rx_stalls_on = 1'b0;
  bit hold_off_req = 1'b0;

  mecanum_wheel_mixer_core #(
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always #10 clk = ~clk;

  // Clamp a wide wheel value into the motor command range.
  function automatic cmd_t clamp_cmd(input longint v);
    if (v > mwm_pkg::CMD_MAX) begin
      return cmd_t'(mwm_pkg::CMD_MAX);
    end
    if (v < mwm_pkg::CMD_MIN) begin
      return cmd_t'(mwm_pkg::CMD_MIN);
    end
    return cmd_t'(v);
  endfunction

  // Wheel speeds from one drive command, normalised when the peak exceeds 1.0.
  function automatic mwm_pkg::mix_word_t mix_wheels(input mwm_pkg::cmd_word_t c);
    longint             strafe, fwd, rot, peak, one_fix, a;
    longint             wheel[mwm_pkg::NUM_WHEELS];
    mwm_pkg::mix_word_t m;
    one_fix = longint'(1) << FRAC_BITS;
    strafe = longint'($signed(c.strafe_cmd));
    fwd = -longint'($signed(c.axis_cmd));
    rot = longint'($signed(c.rotate_cmd));
    wheel[mwm_pkg::LANE_FL] = fwd + rot + strafe;
    wheel[mwm_pkg::LANE_FR] = fwd - rot - strafe;
    wheel[mwm_pkg::LANE_RL] = fwd + rot - strafe;
    wheel[mwm_pkg::LANE_RR] = fwd - rot + strafe;
    peak = 0;
    for (int i = 0; i < mwm_pkg::NUM_WHEELS; i++) begin
      a = (wheel[i] < 0) ? -wheel[i] : wheel[i];
      if (a > peak) peak = a;
    end
    // The quotient is taken on the magnitude and truncated, then signed again.
    if (peak > one_fix) begin
      for (int i = 0; i < mwm_pkg::NUM_WHEELS; i++) begin
        if (wheel[i] < 0) wheel[i] = -((-wheel[i]) * one_fix / peak);
        else wheel[i] = wheel[i] * one_fix / peak;
      end
    end
    m.front_left_out  = clamp_cmd(wheel[mwm_pkg::LANE_FL]);
    m.front_right_out = clamp_cmd(-wheel[mwm_pkg::LANE_FR]);
    m.rear_left_out   = clamp_cmd(wheel[mwm_pkg::LANE_RL]);
    m.rear_right_out  = clamp_cmd(-wheel[mwm_pkg::LANE_RR]);
    return m;
  endfunction

  // Gap length: mostly none, often short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // One random command field; the mode shapes the value range.
  function automatic cmd_t rand_field(input int mode);
    int v;
    case (mode)
      0: begin
        v = int'($urandom_range(0, 16383)) - 8192;
        return cmd_t'(v);
      end
      1: begin
        case ($urandom_range(0, 6))
          0: return cmd_t'(mwm_pkg::CMD_MIN);
          1: return cmd_t'(mwm_pkg::CMD_MIN + 1);
          2: return cmd_t'(-1);
          3: return cmd_t'(0);
          4: return cmd_t'(1);
          5: return cmd_t'(16384);
          default: return cmd_t'(mwm_pkg::CMD_MAX);
        endcase
      end
      default: return cmd_t'($urandom);
    endcase
  endfunction

  function automatic mwm_pkg::cmd_word_t rand_cmd();
    mwm_pkg::cmd_word_t c;
    int                 mode;
    mode = $urandom_range(0, 9);
    if (mode < 3) mode = 0;
    else if (mode < 5) mode = 1;
    else mode = 2;
    c.strafe_cmd = rand_field(mode);
    c.axis_cmd   = rand_field(mode);
    c.rotate_cmd = rand_field(mode);
    return c;
  endfunction

  function automatic mwm_pkg::cmd_word_t make_cmd(input int s, input int a, input int r);
    mwm_pkg::cmd_word_t c;
    c.strafe_cmd = cmd_t'(s);
    c.axis_cmd   = cmd_t'(a);
    c.rotate_cmd = cmd_t'(r);
    return c;
  endfunction

  // Offer one word and hold it until the block takes it.
  task automatic send_cmd(input mwm_pkg::cmd_word_t c);
    @(negedge clk);
    in_valid = 1'b1;
    in_word = c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_mix_q.push_back(mix_wheels(c));
  endtask

  task automatic idle_in(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  task automatic wait_drained();
    while (pending_mix_q.size() != 0) @(posedge clk);
  endtask

  // Extremes, exact unity peak, just above unity and truncating divisions.
  task automatic test_directed();
    send_cmd(make_cmd(0, 0, 0));
    send_cmd(make_cmd(mwm_pkg::CMD_MAX, mwm_pkg::CMD_MAX, mwm_pkg::CMD_MAX));
    send_cmd(make_cmd(mwm_pkg::CMD_MIN, mwm_pkg::CMD_MIN, mwm_pkg::CMD_MIN));
    send_cmd(make_cmd(0, mwm_pkg::CMD_MIN, 0));
    send_cmd(make_cmd(0, mwm_pkg::CMD_MAX, 0));
    send_cmd(make_cmd(mwm_pkg::CMD_MAX, 0, 0));
    send_cmd(make_cmd(mwm_pkg::CMD_MIN, 0, 0));
    send_cmd(make_cmd(0, 0, mwm_pkg::CMD_MAX));
    send_cmd(make_cmd(0, 0, mwm_pkg::CMD_MIN));
    send_cmd(make_cmd(0, -16384, 16384));
    send_cmd(make_cmd(16384, 0, -16384));
    send_cmd(make_cmd(0, -16384, 16385));
    send_cmd(make_cmd(1, -16384, 16384));
    send_cmd(make_cmd(12345, -23456, 7));
    send_cmd(make_cmd(-30001, 29999, -12347));
    send_cmd(make_cmd(mwm_pkg::CMD_MIN, mwm_pkg::CMD_MAX, mwm_pkg::CMD_MIN));
    send_cmd(make_cmd(1, -1, 1));
    send_cmd(make_cmd(-1, 1, -1));
    send_cmd(make_cmd(mwm_pkg::CMD_MAX, mwm_pkg::CMD_MIN, mwm_pkg::CMD_MAX));
    idle_in(1);
    wait_drained();
  endtask

  // Random commands with gaps on both sides and periodic full drains.
  task automatic test_random(input int n);
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    for (int i = 0; i < n; i++) begin
      send_cmd(rand_cmd());
      if (tx_gaps_on) idle_in(gap_len());
      // The sender stops now and then until every owed word has come back.
      if ((i % 200) == 199) begin
        idle_in(1);
        wait_drained();
      end
    end
    idle_in(1);
  endtask

  // Back-to-back words with neither side idling.
  task automatic test_streaming(input int n);
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    for (int i = 0; i < n; i++) begin
      send_cmd(rand_cmd());
    end
    idle_in(1);
  endtask

  // A long receiver hold-off while words keep coming, so the pipe fills.
  task automatic test_backpressure(input int n);
    rx_stalls_on = 1'b0;
    @(posedge clk);
    hold_off_req = 1'b1;
    for (int i = 0; i < n; i++) begin
      send_cmd(rand_cmd());
    end
    idle_in(1);
    while (hold_off_req) @(posedge clk);
    rx_stalls_on = 1'b1;
  endtask

  // Receiver stall driver; a requested hold-off is counted here.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall = 1'b1;
        repeat (HOLD_OFF_LEN - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if (rx_stalls_on) stall_left = gap_len();
      end
    end
  end

  task automatic check_field(input string name, input cmd_t want, input cmd_t got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("Mismatch on %s, word %0d: expected %0d, got %0d", name,
                 words_checked, want, got);
      end
    end
  endtask

  // Compare each output word with the oldest owed word.
  initial begin
    mwm_pkg::mix_word_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_mix_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Unexpected output word %h", out_word);
          end
        end else begin
          want = pending_mix_q.pop_front();
          check_field("front_left_out", want.front_left_out, out_word.front_left_out);
          check_field("front_right_out", want.front_right_out, out_word.front_right_out);
          check_field("rear_left_out", want.rear_left_out, out_word.rear_left_out);
          check_field("rear_right_out", want.rear_right_out, out_word.rear_right_out);
        end
        words_checked++;
      end
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no word has moved for %0d cycles", quiet_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(1350);
    test_streaming(250);
    test_backpressure(80);
    test_random(250);
    wait_drained();
    repeat (LATENCY + 5) @(posedge clk);
    if (mismatch_count == 0 && pending_mix_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
